@@ sv/searchable_fifo_queue_macros.svh @@
// assertion macros used by the searchable fifo queue top level
`ifndef SEARCHABLE_FIFO_QUEUE_MACROS_SVH
`define SEARCHABLE_FIFO_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF

// expression holds at every clock edge out of reset
`define SFQ_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("sfq assertion failed");

// consequent holds in the same cycle as the antecedent
`define SFQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfq assertion failed");

// consequent holds in the cycle after the antecedent
`define SFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfq assertion failed");

`else

`define SFQ_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define SFQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define SFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/sfq_pkg.sv @@
// shared types and constants of the searchable fifo queue
package sfq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int COUNT_W    = $clog2(DEPTH + 1);
    localparam int OPCODE_W   = 3;
    localparam int STATUS_W   = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_FRONT = 3'd2,
        OP_FIND  = 3'd3,
        OP_READ  = 3'd4,
        OP_SWAP  = 3'd5,
        OP_CLEAR = 3'd6
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // per-cell load controls, at most one set in a cycle
    typedef struct packed {
        logic load_push;
        logic take_next;
        logic take_prev;
    } t_cell_ctl;

endpackage

@@ sv/sfq_cell.sv @@
// one storage cell of the queue chain: holds a word, compares it, moves it to a neighbor
module sfq_cell (
    input  logic                           i_clk,
    input  sfq_pkg::t_cell_ctl             i_ctl,
    input  logic [sfq_pkg::DATA_WIDTH-1:0] i_push_word,
    input  logic [sfq_pkg::DATA_WIDTH-1:0] i_prev_word,
    input  logic [sfq_pkg::DATA_WIDTH-1:0] i_next_word,
    input  logic [sfq_pkg::DATA_WIDTH-1:0] i_key,
    output logic [sfq_pkg::DATA_WIDTH-1:0] o_word,
    output logic                           o_match
);

    logic [sfq_pkg::DATA_WIDTH-1:0] r_word;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_push) begin
            r_word <= i_push_word;
        end else if (i_ctl.take_next) begin
            r_word <= i_next_word;
        end else if (i_ctl.take_prev) begin
            r_word <= i_prev_word;
        end
    end

    assign o_word  = r_word;
    assign o_match = (r_word == i_key);

endmodule

@@ sv/searchable_fifo_queue.sv @@
// searchable fifo queue top level: control, chain of storage cells and result register
// the result of a transaction is registered and on the outputs in the cycle after it is accepted
// throughput: one transaction per cycle, busy stays low, since all cells compare, shift or swap
// in parallel along the chain
// reset: synchronous active-low i_rst_n empties the queue and clears the result strobe;
// stored words are not cleared, only entries below the count are ever visible
module searchable_fifo_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [sfq_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [sfq_pkg::DATA_WIDTH-1:0] i_value,
    input  logic [sfq_pkg::IDX_W-1:0]      i_position,
    output logic                           o_valid,
    output logic [sfq_pkg::DATA_WIDTH-1:0] o_data_out,
    output logic [sfq_pkg::IDX_W-1:0]      o_found_position,
    output logic [sfq_pkg::COUNT_W-1:0]    o_count,
    output logic                           o_is_empty,
    output logic [sfq_pkg::STATUS_W-1:0]   o_status
);

`include "searchable_fifo_queue_macros.svh"

    // queue occupancy and result register
    logic [sfq_pkg::COUNT_W-1:0]    r_occ;
    logic [sfq_pkg::COUNT_W-1:0]    n_occ;
    logic                           r_valid;
    logic [sfq_pkg::DATA_WIDTH-1:0] r_data_out;
    logic [sfq_pkg::DATA_WIDTH-1:0] n_data_out;
    logic [sfq_pkg::IDX_W-1:0]      r_found;
    logic [sfq_pkg::IDX_W-1:0]      n_found;
    logic [sfq_pkg::COUNT_W-1:0]    r_count;
    logic                           r_is_empty;
    sfq_pkg::t_status               r_status;
    sfq_pkg::t_status               n_status;

    logic                           accept;
    sfq_pkg::t_opcode               op;
    logic [sfq_pkg::COUNT_W-1:0]    pos_ext;

    // cell chain wiring
    logic [sfq_pkg::DATA_WIDTH-1:0] cell_word  [sfq_pkg::DEPTH];
    logic [sfq_pkg::DEPTH-1:0]      cell_match;
    logic [sfq_pkg::DEPTH-1:0]      hit;
    sfq_pkg::t_cell_ctl             cell_ctl   [sfq_pkg::DEPTH];

    // per-operation qualifiers
    logic                           push_ok;
    logic                           pop_ok;
    logic                           swap_ok;
    logic                           any_hit;
    logic [sfq_pkg::IDX_W-1:0]      first_hit;

    // the block never holds off a transaction, busy is tied low
    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign op      = sfq_pkg::t_opcode'(i_opcode);
    assign pos_ext = {1'b0, i_position};

    assign push_ok = accept && (op == sfq_pkg::OP_PUSH) &&
                     (r_occ < sfq_pkg::COUNT_W'(sfq_pkg::DEPTH));
    assign pop_ok  = accept && (op == sfq_pkg::OP_POP) && (r_occ != '0);
    assign swap_ok = accept && (op == sfq_pkg::OP_SWAP) &&
                     (i_position != '0) && (pos_ext < r_occ);

    // chain of cells: push loads the cell at the tail, pop shifts every live cell
    // toward the front, swap exchanges the addressed cell with its front neighbor
    for (genvar gi = 0; gi < sfq_pkg::DEPTH; gi++) begin : g_cell
        logic [sfq_pkg::DATA_WIDTH-1:0] prev_word;
        logic [sfq_pkg::DATA_WIDTH-1:0] next_word;

        if (gi == 0) begin : g_head
            assign prev_word = '0;
        end else begin : g_body
            assign prev_word = cell_word[gi-1];
        end

        if (gi == sfq_pkg::DEPTH - 1) begin : g_tail
            assign next_word = '0;
        end else begin : g_link
            assign next_word = cell_word[gi+1];
        end

        always_comb begin
            cell_ctl[gi].load_push = push_ok && (r_occ == sfq_pkg::COUNT_W'(gi));
            // pop: cell i takes i+1 while i+1 is still a live entry
            // swap: the front neighbor of the addressed cell takes the addressed word
            cell_ctl[gi].take_next = (pop_ok && (sfq_pkg::COUNT_W'(gi + 1) < r_occ)) ||
                                     (swap_ok && (sfq_pkg::COUNT_W'(gi + 1) == pos_ext));
            cell_ctl[gi].take_prev = swap_ok && (sfq_pkg::COUNT_W'(gi) == pos_ext);
        end

        sfq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl[gi]),
            .i_push_word (i_value),
            .i_prev_word (prev_word),
            .i_next_word (next_word),
            .i_key       (i_value),
            .o_word      (cell_word[gi]),
            .o_match     (cell_match[gi])
        );

        // only entries below the count take part in a search
        assign hit[gi] = cell_match[gi] && (sfq_pkg::COUNT_W'(gi) < r_occ);
    end

    // first matching position: scan from the back so the front-most hit wins
    always_comb begin
        first_hit = '0;
        for (int k = sfq_pkg::DEPTH - 1; k >= 0; k--) begin
            if (hit[k]) begin
                first_hit = sfq_pkg::IDX_W'(k);
            end
        end
    end

    assign any_hit = |hit;

    // result and next occupancy for the accepted transaction
    always_comb begin
        n_occ      = r_occ;
        n_data_out = '0;
        n_found    = '0;
        n_status   = sfq_pkg::ST_OK;
        unique case (op)
            sfq_pkg::OP_PUSH: begin
                if (push_ok) begin
                    n_occ = r_occ + 1'b1;
                end else begin
                    n_status = sfq_pkg::ST_FULL;
                end
            end
            sfq_pkg::OP_POP: begin
                if (pop_ok) begin
                    n_data_out = cell_word[0];
                    n_occ      = r_occ - 1'b1;
                end else begin
                    n_status = sfq_pkg::ST_RANGE;
                end
            end
            sfq_pkg::OP_FRONT: begin
                if (r_occ != '0) begin
                    n_data_out = cell_word[0];
                end else begin
                    n_status = sfq_pkg::ST_RANGE;
                end
            end
            sfq_pkg::OP_FIND: begin
                if (any_hit) begin
                    n_found = first_hit;
                end else begin
                    n_status = sfq_pkg::ST_NOTFOUND;
                end
            end
            sfq_pkg::OP_READ: begin
                if (pos_ext < r_occ) begin
                    n_data_out = cell_word[i_position];
                end else begin
                    n_status = sfq_pkg::ST_RANGE;
                end
            end
            sfq_pkg::OP_SWAP: begin
                if (!swap_ok) begin
                    n_status = sfq_pkg::ST_RANGE;
                end
            end
            sfq_pkg::OP_CLEAR: begin
                n_occ = '0;
            end
            default: begin
                // unused opcode: no change, status ok
                n_occ = r_occ;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_occ <= n_occ;
            end
        end
    end

    // result payload, captured with each transaction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data_out <= n_data_out;
            r_found    <= n_found;
            r_count    <= n_occ;
            r_is_empty <= (n_occ == '0);
            r_status   <= n_status;
        end
    end

    assign o_valid          = r_valid;
    assign o_data_out       = r_data_out;
    assign o_found_position = r_found;
    assign o_count          = r_count;
    assign o_is_empty       = r_is_empty;
    assign o_status         = r_status;

    // checks
    `SFQ_ASSERT_ALWAYS(a_occ_bound, i_clk, i_rst_n, r_occ <= sfq_pkg::COUNT_W'(sfq_pkg::DEPTH))
    `SFQ_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, i_rst_n && accept, o_valid && (o_count == r_occ))
    `SFQ_ASSERT_IMPLIES(a_empty_flag, i_clk, i_rst_n, o_valid, o_is_empty == (o_count == '0))
    `SFQ_ASSERT_IMPLIES(a_full_drop, i_clk, i_rst_n, o_valid && (o_status == sfq_pkg::ST_FULL), o_count == sfq_pkg::COUNT_W'(sfq_pkg::DEPTH))

endmodule

@@ dv/tb_searchable_fifo_queue.sv @@
// self-checking testbench for the searchable fifo queue: directed corner cases, then random traffic
module tb_searchable_fifo_queue;

    // opcode seven has no operation behind it, the block must treat it as a no-op
    localparam logic [sfq_pkg::OPCODE_W-1:0] OP_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam logic [sfq_pkg::DATA_WIDTH-1:0] ALL_ONES = '1;

    // what one result transaction should carry
    typedef struct packed {
        logic [sfq_pkg::DATA_WIDTH-1:0] data;
        logic [sfq_pkg::IDX_W-1:0]      found;
        logic [sfq_pkg::COUNT_W-1:0]    count;
        logic                           is_empty;
        sfq_pkg::t_status               status;
    } t_queue_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic [sfq_pkg::OPCODE_W-1:0]   i_opcode = '0;
    logic [sfq_pkg::DATA_WIDTH-1:0] i_value = '0;
    logic [sfq_pkg::IDX_W-1:0]      i_position = '0;
    logic                           o_valid;
    logic [sfq_pkg::DATA_WIDTH-1:0] o_data_out;
    logic [sfq_pkg::IDX_W-1:0]      o_found_position;
    logic [sfq_pkg::COUNT_W-1:0]    o_count;
    logic                           o_is_empty;
    logic [sfq_pkg::STATUS_W-1:0]   o_status;

    // shadow copy of the queue contents, front at index 0
    logic [sfq_pkg::DATA_WIDTH-1:0] model_words [sfq_pkg::DEPTH];
    int                             model_count = 0;

    t_queue_result pending_results [$];
    t_queue_result oldest;

    int gap_pct = 0;
    int cycles = 0;
    int mismatches = 0;
    int results_checked = 0;
    int items_sent = 0;
    int op_seen [8];
    int pushes_dropped = 0;
    int finds_hit = 0;

    searchable_fifo_queue dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_value          (i_value),
        .i_position       (i_position),
        .o_valid          (o_valid),
        .o_data_out       (o_data_out),
        .o_found_position (o_found_position),
        .o_count          (o_count),
        .o_is_empty       (o_is_empty),
        .o_status         (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // applies one operation to the shadow queue and returns the result it must produce
    function automatic t_queue_result queue_operation(
        input logic [sfq_pkg::OPCODE_W-1:0]   op,
        input logic [sfq_pkg::DATA_WIDTH-1:0] word,
        input logic [sfq_pkg::IDX_W-1:0]      pos
    );
        t_queue_result                  r;
        logic [sfq_pkg::DATA_WIDTH-1:0] held;
        logic                           hit;
        r = '0;
        r.status = sfq_pkg::ST_OK;
        hit = 1'b0;
        case (op)
            sfq_pkg::OP_PUSH: begin
                if (model_count >= sfq_pkg::DEPTH) begin
                    r.status = sfq_pkg::ST_FULL;
                end else begin
                    model_words[model_count] = word;
                    model_count++;
                end
            end
            sfq_pkg::OP_POP: begin
                if (model_count == 0) begin
                    r.status = sfq_pkg::ST_RANGE;
                end else begin
                    r.data = model_words[0];
                    for (int k = 1; k < model_count; k++)
                        model_words[k-1] = model_words[k];
                    model_count--;
                end
            end
            sfq_pkg::OP_FRONT: begin
                if (model_count == 0) r.status = sfq_pkg::ST_RANGE;
                else r.data = model_words[0];
            end
            sfq_pkg::OP_FIND: begin
                // first match from the front wins
                for (int k = 0; k < model_count; k++) begin
                    if (!hit && model_words[k] == word) begin
                        hit = 1'b1;
                        r.found = sfq_pkg::IDX_W'(k);
                    end
                end
                if (hit) r.status = sfq_pkg::ST_OK;
                else r.status = sfq_pkg::ST_NOTFOUND;
            end
            sfq_pkg::OP_READ: begin
                if (pos >= model_count) r.status = sfq_pkg::ST_RANGE;
                else r.data = model_words[pos];
            end
            sfq_pkg::OP_SWAP: begin
                if (pos == 0 || pos >= model_count) begin
                    r.status = sfq_pkg::ST_RANGE;
                end else begin
                    held = model_words[pos];
                    model_words[pos] = model_words[pos-1];
                    model_words[pos-1] = held;
                end
            end
            sfq_pkg::OP_CLEAR: model_count = 0;
            default: ;
        endcase
        r.count = sfq_pkg::COUNT_W'(model_count);
        r.is_empty = (model_count == 0);
        return r;
    endfunction

    // drives one transaction, holds it until accepted, then records what must come back
    task automatic send_op(input logic [sfq_pkg::OPCODE_W-1:0]   op,
                           input logic [sfq_pkg::DATA_WIDTH-1:0] word,
                           input logic [sfq_pkg::IDX_W-1:0]      pos);
        t_queue_result predicted;
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_opcode <= op;
        i_value <= word;
        i_position <= pos;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = queue_operation(op, word, pos);
        pending_results.push_back(predicted);
        items_sent++;
        op_seen[op]++;
        if (predicted.status == sfq_pkg::ST_FULL) pushes_dropped++;
        if (op == sfq_pkg::OP_FIND && predicted.status == sfq_pkg::ST_OK) finds_hit++;
    endtask

    task automatic report_mismatch(input string what,
                                   input logic [sfq_pkg::DATA_WIDTH-1:0] want,
                                   input logic [sfq_pkg::DATA_WIDTH-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch in %s at result %0d: expected %h, got %h",
                     what, results_checked, want, got);
    endtask

    // result checker: the strobe lasts one cycle, so every edge with o_valid is a transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", '0, o_data_out);
            end else begin
                oldest = pending_results.pop_front();
                if (o_data_out !== oldest.data)
                    report_mismatch("data_out", oldest.data, o_data_out);
                if (o_found_position !== oldest.found)
                    report_mismatch("found_position",
                                    sfq_pkg::DATA_WIDTH'(oldest.found),
                                    sfq_pkg::DATA_WIDTH'(o_found_position));
                if (o_count !== oldest.count)
                    report_mismatch("count", sfq_pkg::DATA_WIDTH'(oldest.count),
                                    sfq_pkg::DATA_WIDTH'(o_count));
                if (o_is_empty !== oldest.is_empty)
                    report_mismatch("is_empty", sfq_pkg::DATA_WIDTH'(oldest.is_empty),
                                    sfq_pkg::DATA_WIDTH'(o_is_empty));
                if (o_status !== oldest.status)
                    report_mismatch("status", sfq_pkg::DATA_WIDTH'(oldest.status),
                                    sfq_pkg::DATA_WIDTH'(o_status));
            end
            results_checked++;
        end else if (i_rst_n && o_valid !== 1'b0) begin
            report_mismatch("valid strobe", '0, sfq_pkg::DATA_WIDTH'(o_valid));
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // every operation but push and clear against an empty queue
    task automatic test_empty_queue();
        send_op(sfq_pkg::OP_POP, '0, '0);
        send_op(sfq_pkg::OP_FRONT, '0, '0);
        send_op(sfq_pkg::OP_FIND, '0, '0);
        send_op(sfq_pkg::OP_READ, '0, 4'd15);
        send_op(sfq_pkg::OP_SWAP, '0, 4'd1);
        send_op(OP_UNUSED, ALL_ONES, 4'd15);
    endtask

    // fill to the brim with extreme words, overflow once, then search and read the back end
    task automatic test_fill_and_overflow();
        send_op(sfq_pkg::OP_PUSH, '0, '0);
        send_op(sfq_pkg::OP_PUSH, ALL_ONES, 4'd15);
        send_op(sfq_pkg::OP_PUSH, 32'h5555_5555, '0);
        send_op(sfq_pkg::OP_PUSH, 32'hAAAA_AAAA, '0);
        for (int k = 4; k < sfq_pkg::DEPTH; k++)
            send_op(sfq_pkg::OP_PUSH, (32'h1 << (2 * k)) | k, '0);
        send_op(sfq_pkg::OP_PUSH, 32'hDEAD_BEEF, '0);
        send_op(sfq_pkg::OP_FIND, (32'h1 << 30) | 15, '0);
        send_op(sfq_pkg::OP_FIND, 32'h1234_5678, '0);
        send_op(sfq_pkg::OP_READ, '0, 4'd15);
    endtask

    // swap at the back and at the front, drain one, read past the end, clear
    task automatic test_reorder_and_drain();
        send_op(sfq_pkg::OP_SWAP, '0, 4'd15);
        send_op(sfq_pkg::OP_SWAP, '0, 4'd0);
        send_op(sfq_pkg::OP_POP, '0, '0);
        send_op(sfq_pkg::OP_READ, '0, 4'd15);
        send_op(sfq_pkg::OP_CLEAR, '0, '0);
    endtask

    // bursts of push-heavy or drain-heavy traffic so the queue swings between empty and full
    task automatic test_random_traffic(input int n_items, input int sender_gap);
        logic [sfq_pkg::OPCODE_W-1:0]   op;
        logic [sfq_pkg::DATA_WIDTH-1:0] word;
        logic [sfq_pkg::IDX_W-1:0]      pos;
        int                             push_pct;
        int                             burst_left;
        int                             pick;
        gap_pct = sender_gap;
        burst_left = 0;
        push_pct = 50;
        for (int n = 0; n < n_items; n++) begin
            if (burst_left == 0) begin
                push_pct = $urandom_range(75, 15);
                burst_left = $urandom_range(60, 10);
            end
            burst_left--;
            if ($urandom_range(99) < push_pct) begin
                op = sfq_pkg::OP_PUSH;
            end else begin
                pick = $urandom_range(99);
                if (pick < 25) op = sfq_pkg::OP_POP;
                else if (pick < 40) op = sfq_pkg::OP_FRONT;
                else if (pick < 62) op = sfq_pkg::OP_FIND;
                else if (pick < 80) op = sfq_pkg::OP_READ;
                else if (pick < 95) op = sfq_pkg::OP_SWAP;
                else if (pick < 98) op = sfq_pkg::OP_CLEAR;
                else op = OP_UNUSED;
            end
            // a small pool of words gives duplicates, so find must pick the first copy
            pick = $urandom_range(99);
            if (pick < 40) word = sfq_pkg::DATA_WIDTH'($urandom_range(7));
            else if (pick < 45) word = '0;
            else if (pick < 50) word = ALL_ONES;
            else word = $urandom;
            if (op == sfq_pkg::OP_FIND && model_count > 0 && $urandom_range(1) == 1)
                word = model_words[$urandom_range(model_count - 1)];
            if (model_count > 0 && $urandom_range(99) < 70)
                pos = sfq_pkg::IDX_W'($urandom_range(model_count > 15 ? 15 : model_count));
            else
                pos = sfq_pkg::IDX_W'($urandom_range(15));
            send_op(op, word, pos);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_fill_and_overflow();
        test_reorder_and_drain();
        test_random_traffic(624, 24);
        test_random_traffic(624, 49);
        test_random_traffic(624, 0);

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // results are registered, wait on after the last one for stray strobes
        repeat (4) @(posedge i_clk);

        $display("sent %0d transactions: push %0d pop %0d front %0d find %0d read %0d",
                 items_sent, op_seen[sfq_pkg::OP_PUSH], op_seen[sfq_pkg::OP_POP],
                 op_seen[sfq_pkg::OP_FRONT], op_seen[sfq_pkg::OP_FIND],
                 op_seen[sfq_pkg::OP_READ]);
        $display("swap %0d clear %0d no-op %0d, pushes dropped %0d, finds hit %0d, %0d bad",
                 op_seen[sfq_pkg::OP_SWAP], op_seen[sfq_pkg::OP_CLEAR], op_seen[OP_UNUSED],
                 pushes_dropped, finds_hit, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
